>>> rtl/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types and constants for the grid word search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gws_pkg;

    localparam int ROW_W  = 3;
    localparam int CHAR_W = 8;
    localparam int PAT_W  = 64;
    localparam int LEN_W  = 4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [CHAR_W-1:0] t_byte;

    typedef struct packed {
        logic row_hit;
        logic col_hit;
    } t_lane_hit;

endpackage

`default_nettype wire

>>> rtl/gws_lane.sv
// ----------------------------------------------------------------------------
// gws_lane
// Matches the pattern at every start position of one row and one column.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_lane #(
    parameter int GRID_SIZE = 8
) (
    input  gws_pkg::t_byte                 i_row_bytes [GRID_SIZE],
    input  gws_pkg::t_byte                 i_col_bytes [GRID_SIZE],
    input  logic [gws_pkg::PAT_W-1:0]      i_pattern_chars,
    input  logic [gws_pkg::LEN_W-1:0]      i_pattern_length,
    output gws_pkg::t_lane_hit             o_hit
);
    import gws_pkg::*;

    localparam logic [LEN_W:0] G_CNT = (LEN_W+1)'(GRID_SIZE);

    logic [GRID_SIZE-1:0] w_row_ok;
    logic [GRID_SIZE-1:0] w_col_ok;

    always_comb begin
        for (int s = 0; s < GRID_SIZE; s++) begin
            w_row_ok[s] = ({1'b0, i_pattern_length} + (LEN_W+1)'(s)) <= G_CNT;
            w_col_ok[s] = w_row_ok[s];
            for (int k = 0; k < GRID_SIZE; k++) begin
                if (s + k < GRID_SIZE) begin
                    if (LEN_W'(k) < i_pattern_length) begin
                        if (i_row_bytes[s+k] != i_pattern_chars[8*k +: CHAR_W]) begin
                            w_row_ok[s] = 1'b0;
                        end
                        if (i_col_bytes[s+k] != i_pattern_chars[8*k +: CHAR_W]) begin
                            w_col_ok[s] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign o_hit.row_hit = |w_row_ok;
    assign o_hit.col_hit = |w_col_ok;

endmodule

`default_nettype wire

>>> rtl/gws_merge.sv
// ----------------------------------------------------------------------------
// gws_merge
// Combines the registered lane hits into one found flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_merge #(
    parameter int GRID_SIZE = 8
) (
    input  gws_pkg::t_lane_hit i_hits [GRID_SIZE],
    input  logic               i_query,
    output logic               o_found
);
    import gws_pkg::*;

    logic w_any;

    always_comb begin
        w_any = 1'b0;
        for (int l = 0; l < GRID_SIZE; l++) begin
            w_any = w_any | i_hits[l].row_hit | i_hits[l].col_hit;
        end
    end

    assign o_found = i_query & w_any;

endmodule

`default_nettype wire

>>> rtl/grid_word_search_top.sv
// ----------------------------------------------------------------------------
// grid_word_search_top
// Byte grid with row and column pattern search; one lane per row and column pair.
// ----------------------------------------------------------------------------
// An accepted beat is registered as lane hits in stage 1, then as a found flag in the output.
// Throughput: one beat per cycle unless stalled; lanes compare every start position at once.
// A write is visible to a query accepted in the next cycle.
// Reset clears the grid to zero and empties both pipeline stages.
`default_nettype none

module grid_word_search_top #(
    parameter int GRID_SIZE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [gws_pkg::ROW_W-1:0]     i_row,
    input  logic [gws_pkg::ROW_W-1:0]     i_col,
    input  logic [gws_pkg::CHAR_W-1:0]    i_cell_char,
    input  logic [gws_pkg::PAT_W-1:0]     i_pattern_chars,
    input  logic [gws_pkg::LEN_W-1:0]     i_pattern_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found
);
    import gws_pkg::*;

    localparam logic [LEN_W-1:0] G_LEN = LEN_W'(GRID_SIZE);

    t_byte     r_grid [GRID_SIZE][GRID_SIZE];
    t_byte     w_rows [GRID_SIZE][GRID_SIZE];
    t_byte     w_cols [GRID_SIZE][GRID_SIZE];
    t_lane_hit w_hits [GRID_SIZE];
    t_lane_hit r_s1_hits [GRID_SIZE];
    logic      r_s1_valid;
    logic      r_s1_query;
    logic      r_out_valid;
    logic      r_found;
    logic      w_found;
    logic      w_s1_move;
    logic      w_in_acc;
    logic      w_s1_any;

    assign w_s1_move  = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~w_s1_move;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    always_comb begin
        for (int a = 0; a < GRID_SIZE; a++) begin
            for (int b = 0; b < GRID_SIZE; b++) begin
                w_rows[a][b] = r_grid[a][b];
                w_cols[a][b] = r_grid[b][a];
            end
        end
    end

    for (genvar g = 0; g < GRID_SIZE; g++) begin : g_lane
        gws_lane #(
            .GRID_SIZE (GRID_SIZE)
        ) u_lane (
            .i_row_bytes      (w_rows[g]),
            .i_col_bytes      (w_cols[g]),
            .i_pattern_chars  (i_pattern_chars),
            .i_pattern_length (i_pattern_length),
            .o_hit            (w_hits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                for (int c = 0; c < GRID_SIZE; c++) begin
                    r_grid[r][c] <= '0;
                end
            end
        end else if (w_in_acc && i_kind == KIND_WRITE) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                for (int c = 0; c < GRID_SIZE; c++) begin
                    if (i_row == ROW_W'(r) && i_col == ROW_W'(c)) begin
                        r_grid[r][c] <= i_cell_char;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_query <= (i_kind == KIND_QUERY);
            r_s1_hits  <= w_hits;
        end
    end

    gws_merge #(
        .GRID_SIZE (GRID_SIZE)
    ) u_merge (
        .i_hits  (r_s1_hits),
        .i_query (r_s1_query),
        .o_found (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_found <= w_found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    always_comb begin
        w_s1_any = 1'b0;
        for (int l = 0; l < GRID_SIZE; l++) begin
            w_s1_any = w_s1_any | r_s1_hits[l].row_hit | r_s1_hits[l].col_hit;
        end
    end

    a_empty_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == KIND_QUERY && i_pattern_length == '0) |=> w_s1_any)
        else $error("empty pattern produced no lane hit");

    a_long_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == KIND_QUERY && i_pattern_length > G_LEN) |=> !w_s1_any)
        else $error("over-long pattern produced a lane hit");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> r_out_valid)
        else $error("stage beat lost on its way to the output");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && !r_s1_query) |=> !r_found)
        else $error("write beat reported found");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_s1_move)
        else $error("held output overwritten");

endmodule

`default_nettype wire
